// ----- hdl/drlf_pkg.sv -----
// ----------------------------------------------------------------------------
// drlf_pkg
// Shared types and constants for the duplicate and rate limit filter: field
// widths, table entry layouts, register indexes and compare unit status.
// ----------------------------------------------------------------------------
package drlf_pkg;

  // field widths
  localparam int SENDER_W = 32;
  localparam int PACKET_W = 32;
  localparam int TIME_W   = 63;
  localparam int LIMIT_W  = 40;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUP_WINDOW    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_INTERVAL = 1'b1;

  // register reset values
  localparam logic [LIMIT_W-1:0] DUP_WINDOW_RST    = 40'd600000000;
  localparam logic [LIMIT_W-1:0] RATE_INTERVAL_RST = 40'd10000000;

  // recent-packet table entry
  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [PACKET_W-1:0] packet;
    logic [TIME_W-1:0]   stamp;
  } dup_entry_t;

  // per-sender table entry
  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [TIME_W-1:0]   stamp;
  } rate_entry_t;

  // which table the compare unit is checking
  typedef enum logic {
    MODE_DUP  = 1'b0,
    MODE_RATE = 1'b1
  } cmp_mode_t;

  // registered compare unit status
  typedef struct packed {
    logic vld;
    logic match;
    logic young;
  } cmp_res_t;

endpackage

// ----- hdl/drlf_ram.sv -----
// ----------------------------------------------------------------------------
// drlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/drlf_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// drlf_cmp_unit
// Shared compare unit: checks one table entry per cycle against the request
// key and tells whether it matches and whether it is younger than the limit.
// ----------------------------------------------------------------------------
module drlf_cmp_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_vld,
  input  drlf_pkg::cmp_mode_t              mode,
  input  logic [drlf_pkg::SENDER_W-1:0]    key_sender,
  input  logic [drlf_pkg::PACKET_W-1:0]    key_packet,
  input  logic [drlf_pkg::TIME_W-1:0]      key_time,
  input  logic [drlf_pkg::SENDER_W-1:0]    ent_sender,
  input  logic [drlf_pkg::PACKET_W-1:0]    ent_packet,
  input  logic [drlf_pkg::TIME_W-1:0]      ent_time,
  input  logic [drlf_pkg::LIMIT_W-1:0]     dup_window,
  input  logic [drlf_pkg::LIMIT_W-1:0]     rate_interval,
  output drlf_pkg::cmp_res_t               res
);

  logic [drlf_pkg::LIMIT_W-1:0]  limit;
  logic [drlf_pkg::TIME_W:0]     expiry;
  logic                          young;
  logic                          match;

  // younger means now < stamp + limit; a stamp in the future counts as young
  always_comb begin
    limit  = (mode == drlf_pkg::MODE_RATE) ? rate_interval : dup_window;
    expiry = {1'b0, ent_time} + (drlf_pkg::TIME_W + 1)'(limit);
    young  = ({1'b0, key_time} < expiry);
    match  = (ent_sender == key_sender) &&
             ((mode == drlf_pkg::MODE_RATE) || (ent_packet == key_packet));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= req_vld;
    end
    res.match <= match;
    res.young <= young;
  end

endmodule

// ----- hdl/duplicate_and_rate_limit_filter_unit.sv -----
// ----------------------------------------------------------------------------
// duplicate_and_rate_limit_filter_unit
// Refuses duplicate requests and requests from senders inside their rate
// interval; records accepted requests in two round-robin tables.
// ----------------------------------------------------------------------------
// One request is handled at a time. After a request is taken the sequencer
// streams the filled part of the recent-packet table, then of the per-sender
// table, through one shared compare unit, one entry per cycle, and stops at
// the first hit. A scan is shorter while the tables are still filling or when
// a hit ends it early; the scan rate is set by the single read port of each
// table RAM. in_stall stays high from acceptance until the reply has been
// taken. Only entries below each table's fill count are scanned, so no
// clearing pass is needed after reset.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module duplicate_and_rate_limit_filter_unit #(
  parameter int DUP_DEPTH  = 128,
  parameter int RATE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [drlf_pkg::SENDER_W-1:0]   sender_id,
  input  logic [drlf_pkg::PACKET_W-1:0]   packet_num,
  input  logic [drlf_pkg::TIME_W-1:0]     timestamp,
  // reply channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            refused,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drlf_pkg::LIMIT_W-1:0]    cfg_data
);

  localparam int DUP_AW  = $clog2(DUP_DEPTH);
  localparam int RATE_AW = $clog2(RATE_DEPTH);
  localparam int DUP_FW  = $clog2(DUP_DEPTH + 1);
  localparam int RATE_FW = $clog2(RATE_DEPTH + 1);
  localparam int MAX_DEPTH = (DUP_DEPTH > RATE_DEPTH) ? DUP_DEPTH : RATE_DEPTH;
  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SCAN_DUP  = 5'b00010,
    ST_SCAN_RATE = 5'b00100,
    ST_UPDATE    = 5'b01000,
    ST_REPLY     = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [CNT_W-1:0]                scan_cnt;
  logic                            s1_vld;
  logic [RATE_AW-1:0]              s1_idx;
  logic [RATE_AW-1:0]              s2_idx;
  logic [drlf_pkg::SENDER_W-1:0]   key_sender;
  logic [drlf_pkg::PACKET_W-1:0]   key_packet;
  logic [drlf_pkg::TIME_W-1:0]     key_time;
  logic [drlf_pkg::LIMIT_W-1:0]    dup_window;
  logic [drlf_pkg::LIMIT_W-1:0]    rate_interval;
  logic [DUP_AW-1:0]               dup_ptr;
  logic [DUP_FW-1:0]               dup_fill;
  logic [RATE_AW-1:0]              rate_ptr;
  logic [RATE_FW-1:0]              rate_fill;
  logic                            found;
  logic [RATE_AW-1:0]              found_idx;

  logic                            scanning;
  logic                            issue;
  logic                            drained;
  logic [CNT_W-1:0]                scan_fill;
  drlf_pkg::cmp_mode_t             mode;
  drlf_pkg::cmp_res_t              res;
  logic                            dup_hit;

  logic [$bits(drlf_pkg::dup_entry_t)-1:0]  dup_rd;
  logic [$bits(drlf_pkg::rate_entry_t)-1:0] rate_rd;
  drlf_pkg::dup_entry_t            dup_ent;
  drlf_pkg::rate_entry_t           rate_ent;
  drlf_pkg::dup_entry_t            dup_wr;
  drlf_pkg::rate_entry_t           rate_wr;
  logic                            upd_we;
  logic [RATE_AW-1:0]              rate_waddr;
  logic [drlf_pkg::SENDER_W-1:0]   ent_sender;

  // handshake outputs
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_REPLY);
  assign cfg_ready = 1'b1;

  // scan control
  always_comb begin
    scanning  = (state == ST_SCAN_DUP) || (state == ST_SCAN_RATE);
    mode      = (state == ST_SCAN_RATE) ? drlf_pkg::MODE_RATE : drlf_pkg::MODE_DUP;
    scan_fill = (state == ST_SCAN_RATE) ? CNT_W'(rate_fill) : CNT_W'(dup_fill);
    issue     = scanning && (scan_cnt < scan_fill);
    drained   = !issue && !s1_vld && !res.vld;
    dup_hit   = res.vld && res.match && res.young;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN_DUP;
        end
      end
      ST_SCAN_DUP: begin
        if (dup_hit) begin
          state_next = ST_REPLY;
        end else if (drained) begin
          state_next = ST_SCAN_RATE;
        end
      end
      ST_SCAN_RATE: begin
        if (res.vld && res.match) begin
          state_next = res.young ? ST_REPLY : ST_UPDATE;
        end else if (drained) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      s1_vld    <= 1'b0;
      dup_ptr   <= '0;
      dup_fill  <= '0;
      rate_ptr  <= '0;
      rate_fill <= '0;
      found     <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= issue;
      if (state == ST_IDLE) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN_DUP && state_next == ST_SCAN_RATE) begin
        scan_cnt <= '0;
        found    <= 1'b0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if (state == ST_SCAN_RATE && state_next == ST_UPDATE && res.vld) begin
        found <= 1'b1;
      end
      if (state == ST_UPDATE) begin
        dup_ptr <= (dup_ptr == DUP_AW'(DUP_DEPTH - 1)) ? '0 : dup_ptr + DUP_AW'(1);
        if (dup_fill != DUP_FW'(DUP_DEPTH)) begin
          dup_fill <= dup_fill + DUP_FW'(1);
        end
        if (!found) begin
          rate_ptr <= (rate_ptr == RATE_AW'(RATE_DEPTH - 1)) ? '0
                                                              : rate_ptr + RATE_AW'(1);
          if (rate_fill != RATE_FW'(RATE_DEPTH)) begin
            rate_fill <= rate_fill + RATE_FW'(1);
          end
        end
      end
    end
  end

  // request key, index pipeline and reply payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      key_sender <= sender_id;
      key_packet <= packet_num;
      key_time   <= timestamp;
    end
    s1_idx <= scan_cnt[RATE_AW-1:0];
    s2_idx <= s1_idx;
    if (state == ST_SCAN_RATE && res.vld && res.match) begin
      found_idx <= s2_idx;
    end
    if (state != ST_REPLY && state_next == ST_REPLY) begin
      refused <= (state != ST_UPDATE);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_window    <= drlf_pkg::DUP_WINDOW_RST;
      rate_interval <= drlf_pkg::RATE_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drlf_pkg::REG_DUP_WINDOW:    dup_window    <= cfg_data;
        drlf_pkg::REG_RATE_INTERVAL: rate_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // table write data
  always_comb begin
    upd_we         = (state == ST_UPDATE);
    dup_wr.sender  = key_sender;
    dup_wr.packet  = key_packet;
    dup_wr.stamp   = key_time;
    rate_wr.sender = key_sender;
    rate_wr.stamp  = key_time;
    rate_waddr     = found ? found_idx : rate_ptr;
    dup_ent        = drlf_pkg::dup_entry_t'(dup_rd);
    rate_ent       = drlf_pkg::rate_entry_t'(rate_rd);
    ent_sender     = (mode == drlf_pkg::MODE_RATE) ? rate_ent.sender : dup_ent.sender;
  end

  // recent-packet table
  drlf_ram #(
    .WIDTH ($bits(drlf_pkg::dup_entry_t)),
    .DEPTH (DUP_DEPTH)
  ) u_dup_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (dup_ptr),
    .wdata (dup_wr),
    .raddr (scan_cnt[DUP_AW-1:0]),
    .rdata (dup_rd)
  );

  // per-sender table
  drlf_ram #(
    .WIDTH ($bits(drlf_pkg::rate_entry_t)),
    .DEPTH (RATE_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (rate_waddr),
    .wdata (rate_wr),
    .raddr (scan_cnt[RATE_AW-1:0]),
    .rdata (rate_rd)
  );

  // shared compare unit
  drlf_cmp_unit u_cmp (
    .clk           (clk),
    .rst           (rst),
    .req_vld       (s1_vld && scanning),
    .mode          (mode),
    .key_sender    (key_sender),
    .key_packet    (key_packet),
    .key_time      (key_time),
    .ent_sender    (ent_sender),
    .ent_packet    (dup_ent.packet),
    .ent_time      ((mode == drlf_pkg::MODE_RATE) ? rate_ent.stamp : dup_ent.stamp),
    .dup_window    (dup_window),
    .rate_interval (rate_interval),
    .res           (res)
  );

  // no new request while a reply is pending
  a_reply_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while reply pending");

  // a duplicate hit produces a refusal
  a_dup_hit_refuses: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_DUP && dup_hit) |=> (out_valid && refused))
    else $error("duplicate hit not refused");

  // fill count never passes the table depth
  a_dup_fill_bound: assert property (@(posedge clk) disable iff (rst)
    dup_fill <= DUP_FW'(DUP_DEPTH))
    else $error("recent-packet fill count overflow");

  // a refreshed sender entry lies in the filled part of the table
  a_refresh_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && found) |-> (RATE_FW'(found_idx) < rate_fill))
    else $error("refresh of unfilled sender entry");

endmodule
